// ===== hdl/rppt_pkg.sv =====
// Package for the rigid pose point transform: constants, register indexes,
// rotation rebuild sequencer states and the rotation term table.
// No dependencies.
`default_nettype none

package rppt_pkg;

    localparam int COORD_BITS = 32;
    localparam int ANGLE_BITS = 16;
    localparam int ROT_BITS   = 18;
    localparam int CFG_IDX_BITS = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_X    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Y    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Z    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ANGLE_PITCH = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ANGLE_YAW   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_ANGLE_ROLL  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIRECTION   = 3'd6;

    // Fixed-point constants (Q30 sine evaluation, ROT_ONE in Q16)
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [14:0] QUARTER     = 15'h4000;
    localparam logic signed [ROT_BITS-1:0] ROT_ONE = 18'sd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XMUL,
        ST_X2MUL,
        ST_PMUL,
        ST_DIV,
        ST_TUPD,
        ST_SMUL,
        ST_SOUT,
        ST_EMUL1,
        ST_EMUL2,
        ST_EACC,
        ST_ESTORE
    } rb_state_t;

    typedef enum logic [2:0] {
        F_SA, F_CA, F_SB, F_CB, F_SG, F_CG, F_ONE, F_ZERO
    } factor_t;

    typedef struct packed {
        factor_t f1;
        factor_t f2;
        factor_t f3;
        logic    neg;
    } term_t;

    // Reciprocal of one Horner divisor: divisor = 2^pre * odd, and
    // floor(n / divisor) = ((n >> pre) * mul) >> sh for any 32-bit n
    typedef struct packed {
        logic [1:0]  pre;
        logic [31:0] mul;
        logic [5:0]  sh;
    } recip_t;

    // Horner divisors of the sine series, innermost first
    function automatic recip_t horner_recip(input logic [2:0] step);
        recip_t r;
        case (step)
            3'd0:    r = '{2'd1, 32'd2498890064, 6'd37};  // 110 = 2 * 55
            3'd1:    r = '{2'd3, 32'd954437177,  6'd33};  // 72 = 8 * 9
            3'd2:    r = '{2'd1, 32'd3272356036, 6'd36};  // 42 = 2 * 21
            3'd3:    r = '{2'd2, 32'd1717986919, 6'd33};  // 20 = 4 * 5
            default: r = '{2'd1, 32'd2863311531, 6'd33};  // 6 = 2 * 3
        endcase
        return r;
    endfunction

    // Two product terms per rotation entry, R = Rz(roll)*Ry(yaw)*Rx(pitch)
    function automatic term_t term_lookup(input logic [3:0] ent, input logic second);
        term_t t;
        t = '{F_ZERO, F_ZERO, F_ZERO, 1'b0};
        case (ent)
            4'd0: t = second ? t : '{F_CG, F_CB, F_ONE, 1'b0};
            4'd1: t = second ? '{F_SG, F_CA, F_ONE, 1'b1} : '{F_CG, F_SB, F_SA, 1'b0};
            4'd2: t = second ? '{F_SG, F_SA, F_ONE, 1'b0} : '{F_CG, F_SB, F_CA, 1'b0};
            4'd3: t = second ? t : '{F_SG, F_CB, F_ONE, 1'b0};
            4'd4: t = second ? '{F_CG, F_CA, F_ONE, 1'b0} : '{F_SG, F_SB, F_SA, 1'b0};
            4'd5: t = second ? '{F_CG, F_SA, F_ONE, 1'b1} : '{F_SG, F_SB, F_CA, 1'b0};
            4'd6: t = second ? t : '{F_SB, F_ONE, F_ONE, 1'b1};
            4'd7: t = second ? t : '{F_CB, F_SA, F_ONE, 1'b0};
            4'd8: t = second ? t : '{F_CB, F_CA, F_ONE, 1'b0};
            default: t = '{F_ZERO, F_ZERO, F_ZERO, 1'b0};
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rigid_pose_point_transform.sv =====
// Rigid pose point transform: rotation rebuild sequencer and point pipeline.
// Depends on rppt_pkg.
//
// Usage:
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
//   writes offsets, the three binary angles and the direction bit. A write
//   to an angle starts a rebuild of the nine rotation entries from sines and
//   cosines; the rebuild runs on shared multipliers, divides by the series
//   constants through reciprocal multiplication; while it runs, cfg_ready
//   and s_ready are low.
//   The point channel (s_valid/s_ready, s_point_*) takes one point per cycle
//   while s_ready is high. Each point runs through four register stages
//   (translate and split, products, row sums, round/offset/saturate) before
//   m_valid rises; one result leaves per cycle when m_ready is high.
//   When the receiver stalls, each stage holds and bubbles are squeezed out;
//   s_ready drops only once all four stages are full.
//   Reset clears the offsets, angles and direction, loads the identity
//   rotation and empties the pipeline; no rebuild runs after reset.
`default_nettype none

module rigid_pose_point_transform (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [rppt_pkg::COORD_BITS-1:0]  s_point_x,
    input  logic signed [rppt_pkg::COORD_BITS-1:0]  s_point_y,
    input  logic signed [rppt_pkg::COORD_BITS-1:0]  s_point_z,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [rppt_pkg::COORD_BITS-1:0]  m_out_x,
    output logic signed [rppt_pkg::COORD_BITS-1:0]  m_out_y,
    output logic signed [rppt_pkg::COORD_BITS-1:0]  m_out_z,
    output logic                                    m_saturated,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [rppt_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [rppt_pkg::COORD_BITS-1:0]         cfg_data
);
    import rppt_pkg::*;

    // Configuration registers
    logic signed [COORD_BITS-1:0] off_reg [3];
    logic [ANGLE_BITS-1:0]        ang_reg [3];
    logic                         dir_reg;
    logic                         cfg_fire;
    logic                         rebuild_start;
    logic                         busy;

    assign cfg_fire = cfg_valid && cfg_ready;
    assign rebuild_start = cfg_fire && (cfg_index == REG_ANGLE_PITCH ||
                                        cfg_index == REG_ANGLE_YAW ||
                                        cfg_index == REG_ANGLE_ROLL);

    // Store configuration transfers, ignore unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                off_reg[k] <= '0;
                ang_reg[k] <= '0;
            end
            dir_reg <= 1'b0;
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_OFFSET_X:    off_reg[0] <= cfg_data;
                REG_OFFSET_Y:    off_reg[1] <= cfg_data;
                REG_OFFSET_Z:    off_reg[2] <= cfg_data;
                REG_ANGLE_PITCH: ang_reg[0] <= cfg_data[ANGLE_BITS-1:0];
                REG_ANGLE_YAW:   ang_reg[1] <= cfg_data[ANGLE_BITS-1:0];
                REG_ANGLE_ROLL:  ang_reg[2] <= cfg_data[ANGLE_BITS-1:0];
                REG_DIRECTION:   dir_reg    <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Rotation rebuild sequencer
    // ------------------------------------------------------------------
    rb_state_t state_reg, state_next;

    logic [2:0]  sj_reg;      // sine job: angle*2 + complementary
    logic [2:0]  it_reg;      // Horner step
    logic [30:0] x_reg;
    logic [31:0] x2_reg;
    logic [30:0] t_reg;
    logic [31:0] p_reg;
    logic [31:0] quo_reg;
    logic [16:0] sq_reg [6];
    logic [3:0]  ent_reg;
    logic        term_reg;
    logic signed [34:0] m1_reg;
    logic signed [51:0] m2_reg;
    logic signed [51:0] acc_reg;
    logic signed [ROT_BITS-1:0] rot_reg [9];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (rebuild_start) state_next = ST_XMUL;
            ST_XMUL:   state_next = ST_X2MUL;
            ST_X2MUL:  state_next = ST_PMUL;
            ST_PMUL:   state_next = ST_DIV;
            ST_DIV:    state_next = ST_TUPD;
            ST_TUPD:   state_next = (it_reg == 3'd4) ? ST_SMUL : ST_PMUL;
            ST_SMUL:   state_next = ST_SOUT;
            ST_SOUT:   state_next = (sj_reg == 3'd5) ? ST_EMUL1 : ST_XMUL;
            ST_EMUL1:  state_next = ST_EMUL2;
            ST_EMUL2:  state_next = ST_EACC;
            ST_EACC:   state_next = term_reg ? ST_ESTORE : ST_EMUL1;
            ST_ESTORE: state_next = (ent_reg == 4'd8) ? ST_IDLE : ST_EMUL1;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;

    // Sine datapath
    logic [ANGLE_BITS-1:0] ang_sel;
    logic [14:0] r_val;
    logic [45:0] xprod;
    logic [61:0] x2prod;
    logic [62:0] pprod;
    logic [61:0] sprod;
    recip_t      recip_w;
    logic [31:0] p_pre;
    logic [63:0] qprod;
    logic [63:0] q_shr;
    logic [30:0] d_clip;
    logic [30:0] s_clip;
    logic [30:0] s_round;

    always_comb begin
        ang_sel = ang_reg[sj_reg[2:1]];
        r_val   = sj_reg[0] ? (QUARTER - {1'b0, ang_sel[13:0]}) : {1'b0, ang_sel[13:0]};
        xprod   = 46'(r_val) * 46'(HALF_PI_Q30);
        x2prod  = 62'(x_reg) * 62'(x_reg);
        pprod   = 63'(x2_reg) * 63'(t_reg);
        sprod   = 62'(x_reg) * 62'(t_reg);
        // Divide by the Horner constant through its reciprocal
        recip_w = horner_recip(it_reg);
        p_pre   = p_reg >> recip_w.pre;
        qprod   = 64'(p_pre) * 64'(recip_w.mul);
        q_shr   = qprod >> recip_w.sh;
        d_clip  = (quo_reg > 32'(Q30_ONE)) ? Q30_ONE : quo_reg[30:0];
        s_clip  = (p_reg > 32'(Q30_ONE)) ? Q30_ONE : p_reg[30:0];
        s_round = s_clip + 31'd8192;
    end

    // Signed sines and cosines per angle, quadrant applied
    logic signed [ROT_BITS-1:0] sn_w [3];
    logic signed [ROT_BITS-1:0] cs_w [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (ang_reg[k][ANGLE_BITS-1 -: 2])
                2'd0: begin
                    sn_w[k] = $signed({1'b0, sq_reg[2*k]});
                    cs_w[k] = $signed({1'b0, sq_reg[2*k+1]});
                end
                2'd1: begin
                    sn_w[k] = $signed({1'b0, sq_reg[2*k+1]});
                    cs_w[k] = -$signed({1'b0, sq_reg[2*k]});
                end
                2'd2: begin
                    sn_w[k] = -$signed({1'b0, sq_reg[2*k]});
                    cs_w[k] = -$signed({1'b0, sq_reg[2*k+1]});
                end
                default: begin
                    sn_w[k] = -$signed({1'b0, sq_reg[2*k+1]});
                    cs_w[k] = $signed({1'b0, sq_reg[2*k]});
                end
            endcase
        end
    end

    // Entry datapath
    term_t term_w;
    logic signed [ROT_BITS-1:0] f1v, f2v, f3v;
    logic signed [35:0] m1_full;
    logic signed [52:0] m2_full;
    logic signed [51:0] acc_rnd;
    logic signed [19:0] ent_val;
    logic signed [ROT_BITS-1:0] ent_clip;

    function automatic logic signed [ROT_BITS-1:0] factor_val(
        input factor_t f,
        input logic signed [ROT_BITS-1:0] sa, ca, sb, cb, sg, cg
    );
        logic signed [ROT_BITS-1:0] v;
        case (f)
            F_SA:    v = sa;
            F_CA:    v = ca;
            F_SB:    v = sb;
            F_CB:    v = cb;
            F_SG:    v = sg;
            F_CG:    v = cg;
            F_ONE:   v = ROT_ONE;
            default: v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        term_w  = term_lookup(ent_reg, term_reg);
        f1v     = factor_val(term_w.f1, sn_w[0], cs_w[0], sn_w[1], cs_w[1], sn_w[2], cs_w[2]);
        f2v     = factor_val(term_w.f2, sn_w[0], cs_w[0], sn_w[1], cs_w[1], sn_w[2], cs_w[2]);
        f3v     = factor_val(term_w.f3, sn_w[0], cs_w[0], sn_w[1], cs_w[1], sn_w[2], cs_w[2]);
        m1_full = f1v * f2v;
        m2_full = m1_reg * f3v;
        acc_rnd = acc_reg + 52'sh8000_0000;
        ent_val = acc_rnd[51:32];
        if (ent_val > 20'sd131071) begin
            ent_clip = 18'sd131071;
        end else if (ent_val < -20'sd131072) begin
            ent_clip = -18'sd131072;
        end else begin
            ent_clip = ent_val[ROT_BITS-1:0];
        end
    end

    // Advance the sequencer datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sj_reg   <= '0;
            it_reg   <= '0;
            ent_reg  <= '0;
            term_reg <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                rot_reg[k] <= (k % 4 == 0) ? ROT_ONE : '0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    sj_reg <= '0;
                end
                ST_XMUL: begin
                    x_reg <= xprod[44:14];
                end
                ST_X2MUL: begin
                    x2_reg <= x2prod[61:30];
                    t_reg  <= Q30_ONE;
                    it_reg <= '0;
                end
                ST_PMUL: begin
                    p_reg <= pprod[61:30];
                end
                ST_DIV: begin
                    quo_reg <= q_shr[31:0];
                end
                ST_TUPD: begin
                    t_reg  <= Q30_ONE - d_clip;
                    it_reg <= it_reg + 3'd1;
                end
                ST_SMUL: begin
                    p_reg <= sprod[61:30];
                end
                ST_SOUT: begin
                    sq_reg[sj_reg] <= s_round[30:14];
                    sj_reg   <= sj_reg + 3'd1;
                    ent_reg  <= '0;
                    term_reg <= 1'b0;
                    acc_reg  <= '0;
                end
                ST_EMUL1: begin
                    m1_reg <= m1_full[34:0];
                end
                ST_EMUL2: begin
                    m2_reg <= m2_full[51:0];
                end
                ST_EACC: begin
                    acc_reg  <= term_w.neg ? (acc_reg - m2_reg) : (acc_reg + m2_reg);
                    term_reg <= ~term_reg;
                end
                ST_ESTORE: begin
                    rot_reg[ent_reg] <= ent_clip;
                    ent_reg <= ent_reg + 4'd1;
                    acc_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Point pipeline: four stages, each advances when the next has room
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4    = !v4_reg || m_ready;
    assign adv3    = !v3_reg || adv4;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1 && !busy;

    // Stage 1: subtract translation in inverse mode, split into hi and lo
    logic signed [COORD_BITS:0] q_w [3];
    logic signed [8:0]  hi1_reg [3];
    logic [23:0]        lo1_reg [3];
    logic               dir1_reg, dir2_reg, dir3_reg;

    always_comb begin
        q_w[0] = 33'(s_point_x) - (dir_reg ? 33'(off_reg[0]) : 33'sd0);
        q_w[1] = 33'(s_point_y) - (dir_reg ? 33'(off_reg[1]) : 33'sd0);
        q_w[2] = 33'(s_point_z) - (dir_reg ? 33'(off_reg[2]) : 33'sd0);
    end

    // Stage 2: partial products, transposed rotation in inverse mode
    logic signed [26:0] pa_w [3][3];
    logic signed [42:0] pb_w [3][3];
    logic signed [26:0] pa2_reg [3][3];
    logic signed [42:0] pb2_reg [3][3];
    logic signed [ROT_BITS-1:0] rsel;

    always_comb begin
        rsel = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rsel = dir1_reg ? rot_reg[j*3+i] : rot_reg[i*3+j];
                pa_w[i][j] = rsel * hi1_reg[j];
                pb_w[i][j] = rsel * $signed({1'b0, lo1_reg[j]});
            end
        end
    end

    // Stage 3: row sums
    logic signed [28:0] a3_reg [3];
    logic signed [44:0] b3_reg [3];

    // Stage 4: round, add translation in forward mode, saturate
    logic signed [44:0] b_rnd [3];
    logic signed [37:0] v_w [3];
    logic [COORD_BITS-1:0] o_w [3];
    logic [2:0] clip_w;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            b_rnd[i] = b3_reg[i] + 45'sd32768;
            v_w[i]   = (38'(a3_reg[i]) <<< 8) + 38'(b_rnd[i] >>> 16)
                     + (dir3_reg ? 38'sd0 : 38'(off_reg[i]));
            if (!v_w[i][37] && v_w[i][36:31] != 6'h00) begin
                o_w[i]    = 32'h7FFF_FFFF;
                clip_w[i] = 1'b1;
            end else if (v_w[i][37] && v_w[i][36:31] != 6'h3F) begin
                o_w[i]    = 32'h8000_0000;
                clip_w[i] = 1'b1;
            end else begin
                o_w[i]    = v_w[i][31:0];
                clip_w[i] = 1'b0;
            end
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid && s_ready;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (adv1) begin
            dir1_reg <= dir_reg;
            for (int j = 0; j < 3; j++) begin
                hi1_reg[j] <= q_w[j][32:24];
                lo1_reg[j] <= q_w[j][23:0];
            end
        end
        if (adv2) begin
            dir2_reg <= dir1_reg;
            pa2_reg  <= pa_w;
            pb2_reg  <= pb_w;
        end
        if (adv3) begin
            dir3_reg <= dir2_reg;
            for (int i = 0; i < 3; i++) begin
                a3_reg[i] <= 29'(pa2_reg[i][0]) + 29'(pa2_reg[i][1]) + 29'(pa2_reg[i][2]);
                b3_reg[i] <= 45'(pb2_reg[i][0]) + 45'(pb2_reg[i][1]) + 45'(pb2_reg[i][2]);
            end
        end
        if (adv4) begin
            m_out_x     <= o_w[0];
            m_out_y     <= o_w[1];
            m_out_z     <= o_w[2];
            m_saturated <= |clip_w;
        end
    end

    assign m_valid = v4_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> (!s_ready && !cfg_ready))
        else $error("transfer enabled during rotation rebuild");

    a_angle_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        rebuild_start |=> (state_reg == ST_XMUL))
        else $error("angle write did not start a rebuild");

    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_out_x == 32'h7FFF_FFFF || m_out_x == 32'h8000_0000 ||
             m_out_y == 32'h7FFF_FFFF || m_out_y == 32'h8000_0000 ||
             m_out_z == 32'h7FFF_FFFF || m_out_z == 32'h8000_0000))
        else $error("saturation flag without a clipped coordinate");

    a_entry_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ESTORE) |-> (ent_reg <= 4'd8))
        else $error("rotation entry index out of range");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && v4_reg && !m_ready) |=> v3_reg)
        else $error("pipeline item dropped during stall");

endmodule

`default_nettype wire

// ===== bench/rppt_checker.sv =====
// Checker for the rigid pose point transform: watches the point, result and
// register channels, predicts each result and compares it field by field.
// Depends on rppt_pkg.
`default_nettype none

module rppt_checker (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    input  logic                                    s_ready,
    input  logic signed [rppt_pkg::COORD_BITS-1:0]  s_point_x,
    input  logic signed [rppt_pkg::COORD_BITS-1:0]  s_point_y,
    input  logic signed [rppt_pkg::COORD_BITS-1:0]  s_point_z,
    input  logic                                    m_valid,
    input  logic                                    m_ready,
    input  logic signed [rppt_pkg::COORD_BITS-1:0]  m_out_x,
    input  logic signed [rppt_pkg::COORD_BITS-1:0]  m_out_y,
    input  logic signed [rppt_pkg::COORD_BITS-1:0]  m_out_z,
    input  logic                                    m_saturated,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic [rppt_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [rppt_pkg::COORD_BITS-1:0]         cfg_data,
    output int                                      fail_count,
    output int                                      pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rppt_pkg::*;

    localparam longint ONE_Q16 = 65536;
    localparam longint CMAX = 64'sd2147483647;
    localparam longint CMIN = -64'sd2147483648;

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic                         sat;
    } pose_result_t;

    // Pose state mirrored from the register transfers
    longint          offset[3];
    logic [ANGLE_BITS-1:0] pitch, yaw, roll;
    logic            inverse;
    longint          rot[9];
    pose_result_t    expected_q[$];

    // Taylor sine of a quarter-turn remainder, Q16 in [0, 65536]
    function automatic longint quarter_sine(input longint unsigned r);
        longint unsigned divs[5];
        longint unsigned x, x2, t, d, s;
        divs = '{110, 72, 42, 20, 6};
        x  = (r * 64'd1686629713) >> (ANGLE_BITS - 2);
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        for (int k = 0; k < 5; k++) begin
            d = ((x2 * t) >> 30) / divs[k];
            if (d > (64'd1 << 30)) d = 64'd1 << 30;
            t = (64'd1 << 30) - d;
        end
        s = (x * t) >> 30;
        if (s > (64'd1 << 30)) s = 64'd1 << 30;
        return longint'((s + 64'd8192) >> 14);
    endfunction

    task automatic sine_cosine(input logic [ANGLE_BITS-1:0] a, output longint sn,
                               output longint cs);
        longint s0, s1;
        longint unsigned r;
        r  = a[ANGLE_BITS-3:0];
        s0 = quarter_sine(r);
        s1 = quarter_sine((64'd1 << (ANGLE_BITS - 2)) - r);
        case (a[ANGLE_BITS-1:ANGLE_BITS-2])
            2'd0: begin sn = s0;  cs = s1;  end
            2'd1: begin sn = s1;  cs = -s0; end
            2'd2: begin sn = -s0; cs = -s1; end
            default: begin sn = -s1; cs = s0; end
        endcase
    endtask

    // Round a Q48 sum half up to Q16 and clamp to the 18-bit entry range
    function automatic longint rot_entry(input longint q48);
        longint v;
        v = (q48 + (64'sd1 <<< 31)) >>> 32;
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        return v;
    endfunction

    task automatic rebuild_rotation();
        longint sa, ca, sb, cb, sg, cg;
        sine_cosine(pitch, sa, ca);
        sine_cosine(yaw, sb, cb);
        sine_cosine(roll, sg, cg);
        rot[0] = rot_entry(cg * cb * ONE_Q16);
        rot[1] = rot_entry(cg * sb * sa - sg * ca * ONE_Q16);
        rot[2] = rot_entry(cg * sb * ca + sg * sa * ONE_Q16);
        rot[3] = rot_entry(sg * cb * ONE_Q16);
        rot[4] = rot_entry(sg * sb * sa + cg * ca * ONE_Q16);
        rot[5] = rot_entry(sg * sb * ca - cg * sa * ONE_Q16);
        rot[6] = rot_entry(-sb * ONE_Q16 * ONE_Q16);
        rot[7] = rot_entry(cb * sa * ONE_Q16);
        rot[8] = rot_entry(cb * ca * ONE_Q16);
    endtask

    function automatic pose_result_t transform_point(input longint px, input longint py,
                                                     input longint pz);
        pose_result_t res;
        longint q[3], hi[3], lo[3], v[3];
        longint a, b, r;
        q = '{px, py, pz};
        res.sat = 1'b0;
        for (int j = 0; j < 3; j++) begin
            if (inverse) q[j] -= offset[j];
            hi[j] = q[j] >>> 24;
            lo[j] = q[j] - (hi[j] <<< 24);
        end
        for (int i = 0; i < 3; i++) begin
            a = 0;
            b = 0;
            for (int j = 0; j < 3; j++) begin
                r = inverse ? rot[j*3+i] : rot[i*3+j];
                a += r * hi[j];
                b += r * lo[j];
            end
            v[i] = a * 256 + ((b + 32768) >>> 16);
            if (!inverse) v[i] += offset[i];
            if (v[i] > CMAX) begin v[i] = CMAX; res.sat = 1'b1; end
            if (v[i] < CMIN) begin v[i] = CMIN; res.sat = 1'b1; end
        end
        res.x = v[0][COORD_BITS-1:0];
        res.y = v[1][COORD_BITS-1:0];
        res.z = v[2][COORD_BITS-1:0];
        return res;
    endfunction

    initial fail_count = 0;

    always @(posedge aclk) begin
        pose_result_t want;
        if (!aresetn) begin
            offset = '{0, 0, 0};
            pitch = '0;
            yaw = '0;
            roll = '0;
            inverse = 1'b0;
            rot = '{ONE_Q16, 0, 0, 0, ONE_Q16, 0, 0, 0, ONE_Q16};
            expected_q.delete();
            pending = 0;
        end else begin
            // Apply register transfers; the block is idle when they happen
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_OFFSET_X:    offset[0] = longint'($signed(cfg_data));
                    REG_OFFSET_Y:    offset[1] = longint'($signed(cfg_data));
                    REG_OFFSET_Z:    offset[2] = longint'($signed(cfg_data));
                    REG_ANGLE_PITCH: begin pitch = cfg_data[ANGLE_BITS-1:0]; rebuild_rotation(); end
                    REG_ANGLE_YAW:   begin yaw = cfg_data[ANGLE_BITS-1:0]; rebuild_rotation(); end
                    REG_ANGLE_ROLL:  begin roll = cfg_data[ANGLE_BITS-1:0]; rebuild_rotation(); end
                    REG_DIRECTION:   inverse = cfg_data[0];
                    default: ;
                endcase
            end
            // Compare the oldest expectation against the result transfer
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with no point outstanding");
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_out_x !== want.x) begin
                        $error("out_x expected %0d got %0d", want.x, m_out_x);
                        fail_count++;
                    end
                    if (m_out_y !== want.y) begin
                        $error("out_y expected %0d got %0d", want.y, m_out_y);
                        fail_count++;
                    end
                    if (m_out_z !== want.z) begin
                        $error("out_z expected %0d got %0d", want.z, m_out_z);
                        fail_count++;
                    end
                    if (m_saturated !== want.sat) begin
                        $error("saturated expected %0b got %0b", want.sat, m_saturated);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_q.push_back(transform_point(longint'(s_point_x),
                                     longint'(s_point_y), longint'(s_point_z)));
            pending = expected_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== bench/rigid_pose_point_transform_test.sv =====
// Top of the rigid pose point transform test: clock, reset, point and register
// stimulus, receiver stalls, watchdog and verdict.
// Depends on rppt_pkg, rigid_pose_point_transform and rppt_checker.
`default_nettype none

module rigid_pose_point_transform_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rppt_pkg::*;

    localparam int PHASES     = 16;
    localparam int PHASE_PTS  = 100;
    localparam int IDLE_LIMIT = 20000;

    // Index with no register behind it
    localparam logic [CFG_IDX_BITS-1:0] REG_NONE = 3'd7;

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready, m_saturated;
    logic signed [COORD_BITS-1:0] s_point_x, s_point_y, s_point_z;
    logic signed [COORD_BITS-1:0] m_out_x, m_out_y, m_out_z;
    logic cfg_valid, cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [COORD_BITS-1:0]   cfg_data;
    int   fail_count, pending, idle_cycles;
    bit   no_gaps;

    rigid_pose_point_transform u_top (.*);

    rppt_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog: abort when no channel moves for too long
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Mostly short gaps, a few long ones, none during a burst stretch
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 55) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver stalls on its own schedule, each stall held for its length
    initial begin
        int n;
        m_ready = 1'b0;
        forever begin
            n = pick_gap();
            m_ready <= (n == 0);
            repeat ((n > 0) ? n : 1) @(negedge aclk);
        end
    end

    task automatic put_point(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
        int n;
        n = pick_gap();
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_point_x <= x;
        s_point_y <= y;
        s_point_z <= z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Write one register once every outstanding result has drained
    task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Angle with random junk above the angle field
    function automatic logic [31:0] angle_word(input logic [15:0] a);
        return {16'($urandom), a};
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(16'h4000 * $urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [31:0] c;
        s_valid = 1'b0;
        s_point_x = '0;
        s_point_y = '0;
        s_point_z = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        no_gaps = 1'b0;
        aresetn = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: identity pose with coordinate extremes
        put_point(32'h0, 32'h0, 32'h0);
        put_point(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
        put_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        // Forward saturation through the offset
        put_reg(REG_OFFSET_X, 32'h7fff_ffff);
        put_reg(REG_OFFSET_Y, 32'h8000_0000);
        put_reg(REG_OFFSET_Z, 32'h0000_0001);
        put_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        put_point(32'h8000_0000, 32'h7fff_ffff, 32'h0);
        // A quarter turn, the pi angle and the angle just below pi
        put_reg(REG_ANGLE_PITCH, angle_word(16'h4000));
        put_reg(REG_ANGLE_YAW, angle_word(16'h8000));
        put_reg(REG_ANGLE_ROLL, angle_word(16'h7fff));
        put_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        put_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        // Inverse mode: subtracting the offset widens past the range
        put_reg(REG_DIRECTION, 32'hffff_fffe);
        put_reg(REG_DIRECTION, 32'h0000_0001);
        put_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        put_point(32'h0, 32'h0, 32'h0);
        // Unknown register index leaves the pose untouched
        put_reg(REG_NONE, 32'hdead_beef);
        put_reg(REG_ANGLE_ROLL, angle_word(16'h2000));
        put_point(32'h1234_5678, 32'hedcb_a988, 32'h0000_8000);
        put_point(32'hffff_8000, 32'h0000_7fff, 32'h8000_0001);

        // Random phases: new pose, then a stream of points
        for (int ph = 0; ph < PHASES; ph++) begin
            for (int r = 0; r < 3; r++) begin
                c = pick_coord();
                put_reg(CFG_IDX_BITS'(REG_OFFSET_X + r), c);
            end
            put_reg(REG_ANGLE_PITCH, angle_word(pick_angle()));
            put_reg(REG_ANGLE_YAW, angle_word(pick_angle()));
            put_reg(REG_ANGLE_ROLL, angle_word(pick_angle()));
            put_reg(REG_DIRECTION, ph[0] ? $urandom | 32'h1 : $urandom & ~32'h1);
            if ($urandom_range(0, 3) == 0) put_reg(REG_NONE, $urandom);
            for (int k = 0; k < PHASE_PTS; k++) begin
                if (k % 25 == 0) no_gaps = ($urandom_range(0, 2) == 0);
                put_point(pick_coord(), pick_coord(), pick_coord());
            end
            no_gaps = 1'b0;
        end
        s_valid <= 1'b0;

        // Drain, then allow a few pipeline lengths for stray results
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ===== rigid_pose_point_transform.f =====
hdl/rppt_pkg.sv
hdl/rigid_pose_point_transform.sv
bench/rppt_checker.sv
bench/rigid_pose_point_transform_test.sv
